// ===== hw/rtl/sha1c_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_pkg
// Shared types, constants and round functions of the SHA-1 compression core.
// ----------------------------------------------------------------------------
package sha1c_pkg;

	localparam int NUM_WORDS  = 16;
	localparam int NUM_ROUNDS = 80;
	localparam int NUM_CV     = 5;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = $clog2(NUM_WORDS);
	localparam int ROUND_W = $clog2(NUM_ROUNDS);
	localparam int CV_W    = $clog2(NUM_CV);

	localparam logic [COUNT_W-1:0] LAST_WORD  = COUNT_W'(NUM_WORDS - 1);
	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);
	localparam logic [CV_W-1:0]    LAST_CV    = CV_W'(NUM_CV - 1);

	localparam logic [ROUND_W-1:0] ROUND_PH1 = ROUND_W'(20);
	localparam logic [ROUND_W-1:0] ROUND_PH2 = ROUND_W'(40);
	localparam logic [ROUND_W-1:0] ROUND_PH3 = ROUND_W'(60);

	typedef struct packed {
		logic [WORD_W-1:0] message_word;
		logic              start_message;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] digest_word;
		logic [2:0]        word_index;
		logic              last;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_CHOOSE,
		PH_PARITY_A,
		PH_MAJORITY,
		PH_PARITY_B
	} phase_t;

	typedef struct packed {
		logic            load_word;
		logic            load_iv;
		logic            init_work;
		logic            run_round;
		phase_t          phase;
		logic            emit;
	} ctl_t;

	function automatic logic [WORD_W-1:0] iv_word(input logic [CV_W-1:0] idx);
		logic [WORD_W-1:0] v;
		unique case (idx)
			CV_W'(0): v = 32'h6745_2301;
			CV_W'(1): v = 32'hefcd_ab89;
			CV_W'(2): v = 32'h98ba_dcfe;
			CV_W'(3): v = 32'h1032_5476;
			default:  v = 32'hc3d2_e1f0;
		endcase
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] k_const(input phase_t ph);
		logic [WORD_W-1:0] v;
		unique case (ph)
			PH_CHOOSE:   v = 32'h5a82_7999;
			PH_PARITY_A: v = 32'h6ed9_eba1;
			PH_MAJORITY: v = 32'h8f1b_bcdc;
			default:     v = 32'hca62_c1d6;
		endcase
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] f_round(input phase_t ph,
		input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] c,
		input logic [WORD_W-1:0] d);
		logic [WORD_W-1:0] v;
		unique case (ph)
			PH_CHOOSE:   v = d ^ (b & (c ^ d));
			PH_MAJORITY: v = (b & c) | (d & (b | c));
			default:     v = b ^ c ^ d;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/sha1c_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_sched
// Message schedule: 16-word shift line, filled by incoming words and
// extended by one word per round.
// ----------------------------------------------------------------------------
module sha1c_sched (
	input  logic                          clk,
	input  sha1c_pkg::ctl_t               ctl,
	input  logic [sha1c_pkg::WORD_W-1:0]  message_word,
	output logic [sha1c_pkg::WORD_W-1:0]  w
);

	logic [sha1c_pkg::WORD_W-1:0] w_q [sha1c_pkg::NUM_WORDS];
	logic [sha1c_pkg::WORD_W-1:0] mix;
	logic [sha1c_pkg::WORD_W-1:0] next_w;

	// taps for w[t-3], w[t-8], w[t-14], w[t-16]
	assign mix    = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign next_w = {mix[sha1c_pkg::WORD_W-2:0], mix[sha1c_pkg::WORD_W-1]};
	assign w      = w_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load_word || ctl.run_round) begin
			for (int i = 0; i < sha1c_pkg::NUM_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[sha1c_pkg::NUM_WORDS-1] <= ctl.load_word ? message_word : next_w;
		end
	end

endmodule

// ===== hw/rtl/sha1c_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_round
// Round datapath: working variables A..E, one round per cycle, and the
// chaining value with its per-word feed-forward add.
// ----------------------------------------------------------------------------
module sha1c_round (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sha1c_pkg::ctl_t               ctl,
	input  logic [sha1c_pkg::WORD_W-1:0]  w,
	output logic [sha1c_pkg::WORD_W-1:0]  digest_word
);

	logic [sha1c_pkg::WORD_W-1:0] cv_q [sha1c_pkg::NUM_CV];
	logic [sha1c_pkg::WORD_W-1:0] wv_q [sha1c_pkg::NUM_CV];
	logic [sha1c_pkg::WORD_W-1:0] digest_q;
	logic [sha1c_pkg::WORD_W-1:0] a_rot;
	logic [sha1c_pkg::WORD_W-1:0] b_rot;
	logic [sha1c_pkg::WORD_W-1:0] t;
	logic [sha1c_pkg::WORD_W-1:0] sum;

	assign a_rot = {wv_q[0][26:0], wv_q[0][31:27]};
	assign b_rot = {wv_q[1][1:0], wv_q[1][31:2]};
	assign t     = a_rot + wv_q[4] + w + sha1c_pkg::k_const(ctl.phase)
		+ sha1c_pkg::f_round(ctl.phase, wv_q[1], wv_q[2], wv_q[3]);
	assign sum   = cv_q[0] + wv_q[0];

	assign digest_word = digest_q;

	// chaining value: reloaded on a start flag, rotated through the adder on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sha1c_pkg::NUM_CV; i++) begin
				cv_q[i] <= sha1c_pkg::iv_word(sha1c_pkg::CV_W'(i));
			end
		end else if (ctl.load_iv) begin
			for (int i = 0; i < sha1c_pkg::NUM_CV; i++) begin
				cv_q[i] <= sha1c_pkg::iv_word(sha1c_pkg::CV_W'(i));
			end
		end else if (ctl.emit) begin
			for (int i = 0; i < sha1c_pkg::NUM_CV - 1; i++) begin
				cv_q[i] <= cv_q[i+1];
			end
			cv_q[sha1c_pkg::NUM_CV-1] <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init_work) begin
			for (int i = 0; i < sha1c_pkg::NUM_CV; i++) begin
				wv_q[i] <= cv_q[i];
			end
		end else if (ctl.run_round) begin
			wv_q[0] <= t;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= b_rot;
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
		end else if (ctl.emit) begin
			for (int i = 0; i < sha1c_pkg::NUM_CV - 1; i++) begin
				wv_q[i] <= wv_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			digest_q <= sum;
		end
	end

endmodule

// ===== hw/rtl/sha1c_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1c_ctrl
// Sequencer: word collection, 80-round loop and five-word result phase.
// ----------------------------------------------------------------------------
module sha1c_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        start_message,
	output logic                        busy,
	output sha1c_pkg::ctl_t             ctl,
	output logic                        result_valid,
	output logic [2:0]                  result_index,
	output logic                        result_last
);

	sha1c_pkg::state_t                 state_q, state_d;
	logic [sha1c_pkg::COUNT_W-1:0]     count_q, count_d;
	logic [sha1c_pkg::COUNT_W-1:0]     pos;
	logic [sha1c_pkg::ROUND_W-1:0]     round_q, round_d;
	logic [sha1c_pkg::CV_W-1:0]        emit_q, emit_d;
	logic                              valid_q;
	logic [2:0]                        index_q;
	logic                              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha1c_pkg::ST_IDLE;
			count_q <= '0;
			round_q <= '0;
			emit_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			round_q <= round_d;
			emit_q  <= emit_d;
			valid_q <= ctl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			index_q <= 3'(emit_q);
			last_q  <= (emit_q == sha1c_pkg::LAST_CV);
		end
	end

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		round_d       = round_q;
		emit_d        = emit_q;
		pos           = start_message ? '0 : count_q;
		ctl.load_word = 1'b0;
		ctl.load_iv   = 1'b0;
		ctl.init_work = 1'b0;
		ctl.run_round = 1'b0;
		ctl.emit      = 1'b0;
		if (round_q < sha1c_pkg::ROUND_PH1) begin
			ctl.phase = sha1c_pkg::PH_CHOOSE;
		end else if (round_q < sha1c_pkg::ROUND_PH2) begin
			ctl.phase = sha1c_pkg::PH_PARITY_A;
		end else if (round_q < sha1c_pkg::ROUND_PH3) begin
			ctl.phase = sha1c_pkg::PH_MAJORITY;
		end else begin
			ctl.phase = sha1c_pkg::PH_PARITY_B;
		end
		unique case (state_q)
			sha1c_pkg::ST_IDLE: begin
				if (start) begin
					ctl.load_word = 1'b1;
					ctl.load_iv   = start_message;
					if (pos == sha1c_pkg::LAST_WORD) begin
						ctl.init_work = 1'b1;
						count_d       = '0;
						round_d       = '0;
						state_d       = sha1c_pkg::ST_ROUND;
					end else begin
						count_d = pos + 1'b1;
					end
				end
			end
			sha1c_pkg::ST_ROUND: begin
				ctl.run_round = 1'b1;
				round_d       = round_q + 1'b1;
				if (round_q == sha1c_pkg::LAST_ROUND) begin
					emit_d  = '0;
					state_d = sha1c_pkg::ST_EMIT;
				end
			end
			sha1c_pkg::ST_EMIT: begin
				ctl.emit = 1'b1;
				emit_d   = emit_q + 1'b1;
				if (emit_q == sha1c_pkg::LAST_CV) begin
					state_d = sha1c_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1c_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != sha1c_pkg::ST_IDLE);
	assign result_valid = valid_q;
	assign result_index = index_q;
	assign result_last  = last_q;

endmodule

// ===== hw/rtl/sha1_block_compress_core.sv =====
`timescale 1ns / 1ps
// Words 1..15 of a block: each is taken on its own start, busy stays low.
// Sixteenth word: 80 rounds on the shared round datapath, then five adds;
// the five results strobe on consecutive cycles, each registered from its
// add, and busy is high through the round and add states.
// Results cannot be stalled.
// Reset loads the SHA-1 initial chaining value and clears the word count.
// ----------------------------------------------------------------------------
// sha1_block_compress_core
// SHA-1 compression core: collects 16 message words, runs 80 rounds with
// the message schedule and emits the five updated chaining words.
// ----------------------------------------------------------------------------
module sha1_block_compress_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sha1c_pkg::in_t     cmd,
	output sha1c_pkg::out_t    result,
	output logic               result_valid
);

	sha1c_pkg::ctl_t               ctl;
	logic [sha1c_pkg::WORD_W-1:0]  w;
	logic [sha1c_pkg::WORD_W-1:0]  digest_word;
	logic [2:0]                    result_index;
	logic                          result_last;

	sha1c_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.start_message (cmd.start_message),
		.busy          (busy),
		.ctl           (ctl),
		.result_valid  (result_valid),
		.result_index  (result_index),
		.result_last   (result_last)
	);

	sha1c_sched u_sched (
		.clk          (clk),
		.ctl          (ctl),
		.message_word (cmd.message_word),
		.w            (w)
	);

	sha1c_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.w           (w),
		.digest_word (digest_word)
	);

	assign result.digest_word = digest_word;
	assign result.word_index  = result_index;
	assign result.last        = result_last;

`ifndef SYNTHESIS
	// results come only out of a busy phase
	a_valid_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without preceding busy cycle");

	// the five results are back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("gap inside result burst");

	// core is free again when the last word goes out
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("busy still high on last result");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last == (result.word_index == 3'd4)))
		else $error("last flag and word index disagree");
`endif

endmodule
